@@ rtl/sqat_pkg.sv @@
// Shared constants and queue entry type for the shell quote argument tokenizer.
`timescale 1ns / 1ps

package sqat_pkg;

    // Characters that steer quoting and word splitting
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_BTICK  = 8'h60;
    localparam logic [7:0] C_SPACE  = 8'h20;

    // Most beats that one input byte can produce
    localparam int unsigned MAX_BEATS = 3;

    // Default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // One queue entry: all beats caused by one input byte
    typedef struct packed {
        logic                       last;   // entry closes the line
        logic                       mark;   // empty end marker, no byte carried
        logic [1:0]                 cnt;    // number of beats, 1 to 3
        logic [MAX_BEATS-1:0][7:0]  bytes;  // beat bytes, beat 0 in slot 0
    } t_entry;

endpackage

@@ rtl/sqat_front.sv @@
// Front end: accepts raw bytes, tracks quoting state and builds queue entries.
`timescale 1ns / 1ps

module sqat_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_in_byte,
    input  logic              i_in_last,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output sqat_pkg::t_entry  o_entry
);

    // Working copy of the scanner state plus the beats built so far
    typedef struct packed {
        logic                                 iq;   // inside quotes
        logic                                 qd;   // open quote is double
        logic                                 ln;   // next byte is literal
        logic                                 ae;   // previous byte was escaped
        logic                                 bp;   // backslash pending in double quotes
        logic                                 wo;   // word open
        logic                                 awe;  // some word emitted
        logic [1:0]                           n;
        logic [sqat_pkg::MAX_BEATS-1:0][7:0]  b;
    } t_work;

    function automatic t_work put_raw(t_work w, logic [7:0] c);
        t_work r;
        r = w;
        if (r.n != 2'd3) begin
            r.b[r.n] = c;
            r.n      = r.n + 2'd1;
        end
        return r;
    endfunction

    function automatic t_work add_byte(t_work w, logic [7:0] c);
        t_work r;
        r = w;
        if (!r.wo) begin
            if (r.awe) begin
                r = put_raw(r, sqat_pkg::C_SPACE);
            end
            r.wo  = 1'b1;
            r.awe = 1'b1;
        end
        r = put_raw(r, c);
        return r;
    endfunction

    function automatic t_work plain_byte(t_work w, logic [7:0] c);
        t_work r;
        r = w;
        if (c == sqat_pkg::C_BSLASH) begin
            if (r.iq) begin
                if (r.qd) begin
                    r.bp = 1'b1;
                end else begin
                    r = add_byte(r, c);
                end
            end else begin
                r.ln = 1'b1;
            end
        end else begin
            if ((c == sqat_pkg::C_SQUOTE || c == sqat_pkg::C_DQUOTE) && !r.ae) begin
                if (r.iq) begin
                    if (c == (r.qd ? sqat_pkg::C_DQUOTE : sqat_pkg::C_SQUOTE)) begin
                        r.iq = 1'b0;
                    end else begin
                        r = add_byte(r, c);
                    end
                end else begin
                    r.iq = 1'b1;
                    r.qd = (c == sqat_pkg::C_DQUOTE);
                end
            end else if (c == sqat_pkg::C_SPACE && !r.iq) begin
                r.wo = 1'b0;
            end else begin
                r = add_byte(r, c);
            end
            r.ae = 1'b0;
        end
        return r;
    endfunction

    logic  r_iq, r_qd, r_ln, r_ae, r_bp, r_wo, r_awe;
    t_work w_start;
    t_work w_done;
    logic  w_accept;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;

    // Classify the byte and build its beats
    always_comb begin
        w_start     = '0;
        w_start.iq  = r_iq;
        w_start.qd  = r_qd;
        w_start.ln  = r_ln;
        w_start.ae  = r_ae;
        w_start.bp  = r_bp;
        w_start.wo  = r_wo;
        w_start.awe = r_awe;
        w_done      = w_start;
        if (w_start.ln) begin
            w_done    = add_byte(w_start, i_in_byte);
            w_done.ln = 1'b0;
            if (!w_start.iq) begin
                w_done.ae = 1'b1;
            end
        end else if (w_start.bp) begin
            w_done.bp = 1'b0;
            if (i_in_byte == sqat_pkg::C_DQUOTE || i_in_byte == sqat_pkg::C_BSLASH ||
                i_in_byte == sqat_pkg::C_DOLLAR || i_in_byte == sqat_pkg::C_BTICK) begin
                w_done = add_byte(w_done, i_in_byte);
            end else begin
                w_done = add_byte(w_done, sqat_pkg::C_BSLASH);
                w_done = plain_byte(w_done, i_in_byte);
            end
        end else begin
            w_done = plain_byte(w_start, i_in_byte);
        end
        // Flush a backslash still pending at end of line
        if (i_in_last && w_done.bp) begin
            w_done = add_byte(w_done, sqat_pkg::C_BSLASH);
        end
    end

    // Form the queue entry; an empty line end still gets a marker beat
    always_comb begin
        o_entry.last  = i_in_last;
        o_entry.mark  = (w_done.n == 2'd0);
        o_entry.cnt   = (w_done.n == 2'd0) ? 2'd1 : w_done.n;
        o_entry.bytes = (w_done.n == 2'd0) ? '0 : w_done.b;
        o_push        = w_accept && (w_done.n != 2'd0 || i_in_last);
    end

    // Hold scanner state; return to reset at end of line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iq  <= 1'b0;
            r_qd  <= 1'b0;
            r_ln  <= 1'b0;
            r_ae  <= 1'b0;
            r_bp  <= 1'b0;
            r_wo  <= 1'b0;
            r_awe <= 1'b0;
        end else if (w_accept) begin
            if (i_in_last) begin
                r_iq  <= 1'b0;
                r_qd  <= 1'b0;
                r_ln  <= 1'b0;
                r_ae  <= 1'b0;
                r_bp  <= 1'b0;
                r_wo  <= 1'b0;
                r_awe <= 1'b0;
            end else begin
                r_iq  <= w_done.iq;
                r_qd  <= w_done.qd;
                r_ln  <= w_done.ln;
                r_ae  <= w_done.ae;
                r_bp  <= w_done.bp;
                r_wo  <= w_done.wo;
                r_awe <= w_done.awe;
            end
        end
    end

endmodule

@@ rtl/sqat_queue.sv @@
// Small queue of beat groups between the front and back ends.
`timescale 1ns / 1ps

module sqat_queue #(
    parameter int unsigned P_DEPTH = sqat_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sqat_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output sqat_pkg::t_entry  o_head,
    output logic              o_empty,
    output logic              o_full
);

    localparam int unsigned PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);

    sqat_pkg::t_entry r_mem [P_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = (r_wr_ptr == PW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/sqat_back.sv @@
// Back end: unpacks queue entries into single output beats behind a register.
`timescale 1ns / 1ps

module sqat_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sqat_pkg::t_entry  i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_byte_valid,
    output logic              o_out_last
);

    typedef struct packed {
        logic [7:0] data;
        logic       bv;
        logic       last;
    } t_beat;

    function automatic t_beat get_beat(sqat_pkg::t_entry e, logic [1:0] idx);
        t_beat r;
        r.data = e.bytes[idx];
        r.bv   = !e.mark;
        r.last = e.last && (idx == e.cnt - 2'd1);
        return r;
    endfunction

    sqat_pkg::t_entry r_ent;
    logic [1:0]       r_idx;
    logic             r_busy;
    logic             r_valid;
    t_beat            r_beat;

    sqat_pkg::t_entry n_ent;
    logic [1:0]       n_idx;
    logic             n_busy;
    logic             n_valid;
    t_beat            n_beat;
    logic             w_load;

    assign w_load = !r_valid || !i_stall;

    // Pick the next beat: rest of the held entry first, else the queue head
    always_comb begin
        o_pop   = 1'b0;
        n_ent   = r_ent;
        n_idx   = r_idx;
        n_busy  = r_busy;
        n_valid = r_valid;
        n_beat  = r_beat;
        if (w_load) begin
            if (r_busy) begin
                n_beat  = get_beat(r_ent, r_idx);
                n_valid = 1'b1;
                n_idx   = r_idx + 2'd1;
                if (r_idx == r_ent.cnt - 2'd1) begin
                    n_busy = 1'b0;
                end
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_beat  = get_beat(i_head, 2'd0);
                n_valid = 1'b1;
                if (i_head.cnt != 2'd1) begin
                    n_busy = 1'b1;
                    n_ent  = i_head;
                    n_idx  = 2'd1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_ent  <= n_ent;
        r_beat <= n_beat;
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_beat.data;
    assign o_byte_valid = r_beat.bv;
    assign o_out_last   = r_beat.last;

endmodule

@@ rtl/shell_quote_arg_tokenizer.sv @@
// Top level of the shell quote argument tokenizer.
// Input channel: one command line byte per beat on i_in_byte, with i_in_last
// on the final byte of the line; a beat is taken when i_valid is high and
// o_stall is low. Output channel: one cleaned byte per beat on o_out_byte,
// o_byte_valid low for the empty end marker, o_out_last on the line's final
// beat; a beat leaves when o_valid is high and i_stall is low.
// The first beat caused by an input byte is written into the queue when
// that byte is taken and then moved into the output register once the back
// end has finished any earlier entry and the output is not stalled.
// Throughput: one input byte per cycle while o_stall is low; the output
// register gives one beat per cycle while i_stall is low. A byte may cause
// up to three beats (separator space, held backslash, the byte itself), and
// the queue absorbs them; o_stall rises only when it is full.
// Reset clears quoting state, the queue and the output valid flag; no beat is
// presented until new input arrives. While i_stall holds, the output beat
// stays put, the queue fills and then o_stall holds off further input.
`timescale 1ns / 1ps

module shell_quote_arg_tokenizer #(
    parameter int unsigned P_QUEUE_DEPTH = sqat_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_out_last
);

    sqat_pkg::t_entry w_push_entry;
    sqat_pkg::t_entry w_head;
    logic             w_push;
    logic             w_pop;
    logic             w_empty;
    logic             w_full;

    sqat_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .i_full    (w_full),
        .o_stall   (o_stall),
        .o_push    (w_push),
        .o_entry   (w_push_entry)
    );

    sqat_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    sqat_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_out_last   (o_out_last)
    );

endmodule
